@@ rtl/mct_pkg.sv @@
// Shared types and constants for the mouse cursor tracker.
`timescale 1ns / 1ps
`default_nettype none
package mct_pkg;

	localparam int SIZE_BITS = 13;
	localparam int IDX_BITS  = 2;
	localparam int IN_W      = 16;

	localparam logic [SIZE_BITS-1:0] WIDTH_RESET  = 13'd800;
	localparam logic [SIZE_BITS-1:0] HEIGHT_RESET = 13'd480;

	localparam logic [IDX_BITS-1:0] REG_WIDTH  = 2'd0;
	localparam logic [IDX_BITS-1:0] REG_HEIGHT = 2'd1;

	typedef enum logic [2:0] {
		ACT_CONNECT    = 3'd0,
		ACT_DISCONNECT = 3'd1,
		ACT_PRESS      = 3'd2,
		ACT_RELEASE    = 3'd3,
		ACT_XMOVE      = 3'd4,
		ACT_YMOVE      = 3'd5,
		ACT_POLL       = 3'd6
	} act_t;

	typedef enum logic [2:0] {
		CONN_NONE = 3'b001,
		CONN_INIT = 3'b010,
		CONN_LIVE = 3'b100
	} conn_t;

	typedef enum logic [3:0] {
		PH_NONE = 4'b0001,
		PH_DOWN = 4'b0010,
		PH_MOVE = 4'b0100,
		PH_UP   = 4'b1000
	} phase_t;

	localparam logic [1:0] PCODE_NONE = 2'd0;
	localparam logic [1:0] PCODE_DOWN = 2'd1;
	localparam logic [1:0] PCODE_MOVE = 2'd2;
	localparam logic [1:0] PCODE_UP   = 2'd3;

	localparam logic [1:0] LINK_OTHER = 2'd0;
	localparam logic [1:0] LINK_INIT  = 2'd1;
	localparam logic [1:0] LINK_LIVE  = 2'd2;
	localparam logic [1:0] LINK_NONE  = 2'd3;

	function automatic logic [1:0] phase_code(input phase_t ph);
		logic [1:0] code;
		unique case (ph)
			PH_NONE: code = PCODE_NONE;
			PH_DOWN: code = PCODE_DOWN;
			PH_MOVE: code = PCODE_MOVE;
			PH_UP:   code = PCODE_UP;
			default: code = PCODE_NONE;
		endcase
		return code;
	endfunction

endpackage
`default_nettype wire

@@ rtl/mct_clamp.sv @@
// Adds a signed byte delta to one coordinate and clamps it to the screen size.
`timescale 1ns / 1ps
`default_nettype none
module mct_clamp
	import mct_pkg::*;
#(
	parameter int COORD_BITS = 12
) (
	input  wire logic [COORD_BITS-1:0] cur,
	input  wire logic [7:0]            delta,
	input  wire logic [SIZE_BITS-1:0]  size,
	output logic      [COORD_BITS-1:0] res
);

	localparam int LIM_W = (COORD_BITS > SIZE_BITS) ? COORD_BITS : SIZE_BITS;
	localparam logic [LIM_W-1:0] CMAX = LIM_W'((32'd1 << COORD_BITS) - 32'd1);

	logic signed [COORD_BITS+1:0] sum;
	logic        [LIM_W-1:0]      sm1;
	logic        [COORD_BITS-1:0] top;

	always_comb begin
		sum = $signed({2'b00, cur}) + $signed({{(COORD_BITS-6){delta[7]}}, delta});
		if (size == '0) begin
			sm1 = '0;
		end else begin
			sm1 = LIM_W'(size) - LIM_W'(1);
		end
		// saturate the limit to the largest coordinate
		top = (sm1 > CMAX) ? CMAX[COORD_BITS-1:0] : sm1[COORD_BITS-1:0];
		if (sum[COORD_BITS+1]) begin
			res = '0;
		end else if (sum[COORD_BITS:0] > {1'b0, top}) begin
			res = top;
		end else begin
			res = sum[COORD_BITS-1:0];
		end
	end

endmodule
`default_nettype wire

@@ rtl/mouse_cursor_tracker.sv @@
// Mouse cursor tracker: event stream in, poll reports out.
//
// Input beats on s_* carry one event each: action in s_tdata[2:0]
// (connect, disconnect, press, release, x move, y move, poll) and value in
// s_tdata[10:3]. Only a poll produces an output beat on m_*; every other
// event just updates the cursor, button mask or link state.
// The user writes screen size on the cfg port (index 0 width, 1 height)
// while the block is idle; the block does not enforce it. Other indexes
// are ignored. Events sit in the input register and are applied from there;
// an applied poll loads the result register, which drives m_tvalid. One
// event per cycle is accepted unless a poll waits for it; the single input
// register feeding the state update and result register sets that rate.
// When the receiver holds m_tready low with a report pending, non-poll
// events keep flowing; a second poll waits in the input register and
// s_tready drops until the pending report is taken.
// Reset clears the cursor to the origin, the button mask and phase, marks
// no device present, restores an 800 by 480 screen and empties both
// registers.
`timescale 1ns / 1ps
`default_nettype none
module mouse_cursor_tracker
	import mct_pkg::*;
#(
	parameter int COORD_BITS = 12
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	// [2:0] action, [10:3] value, [15:11] zero
	input  wire logic [IN_W-1:0]      s_tdata,
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	// x_position, y_position, cursor_phase[1:0], window_refresh, link_code[1:0]
	output logic [((2*COORD_BITS+5+7)/8)*8-1:0] m_tdata,
	input  wire logic                 cfg_we,
	input  wire logic [IDX_BITS-1:0]  cfg_index,
	input  wire logic [SIZE_BITS-1:0] cfg_data
);

	localparam int OUT_BITS = 2*COORD_BITS + 5;
	localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

	logic [SIZE_BITS-1:0] width_q, height_q;

	logic      valid_s1;
	act_t      action_s1;
	logic [7:0] value_s1;

	logic [COORD_BITS-1:0] x_q, y_q, x_d, y_d, x_clamp, y_clamp;
	logic [7:0]            mask_q, mask_d;
	conn_t                 conn_q, conn_d;
	phase_t                phase_q, phase_d;
	logic                  moved_q, moved_d;

	logic                  out_valid_q;
	logic [COORD_BITS-1:0] ox_q, oy_q;
	logic [1:0]            ophase_q, olink_q, link_d;
	logic                  orefresh_q;

	logic       is_poll, adv, out_load, left;
	logic [7:0] dx, dy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WIDTH:  width_q  <= cfg_data;
				REG_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign is_poll  = valid_s1 && (action_s1 == ACT_POLL);
	// a poll may only apply once the result register is free
	assign adv      = valid_s1 && (!is_poll || !out_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			action_s1 <= act_t'(s_tdata[2:0]);
			value_s1  <= s_tdata[10:3];
		end
	end

	assign dx = (action_s1 == ACT_XMOVE) ? value_s1 : 8'd0;
	assign dy = (action_s1 == ACT_YMOVE) ? value_s1 : 8'd0;

	// both axes re-clamp on every move
	mct_clamp #(.COORD_BITS(COORD_BITS)) u_clamp_x (
		.cur   (x_q),
		.delta (dx),
		.size  (width_q),
		.res   (x_clamp)
	);

	mct_clamp #(.COORD_BITS(COORD_BITS)) u_clamp_y (
		.cur   (y_q),
		.delta (dy),
		.size  (height_q),
		.res   (y_clamp)
	);

	assign left = mask_q[0];

	always_comb begin
		x_d      = x_q;
		y_d      = y_q;
		mask_d   = mask_q;
		conn_d   = conn_q;
		phase_d  = phase_q;
		moved_d  = moved_q;
		link_d   = LINK_OTHER;
		out_load = 1'b0;
		if (adv) begin
			unique case (action_s1) inside
				ACT_CONNECT: conn_d = CONN_INIT;
				ACT_DISCONNECT: begin
					conn_d = CONN_NONE;
					mask_d = 8'd0;
				end
				ACT_PRESS:   mask_d = mask_q | value_s1;
				ACT_RELEASE: mask_d = mask_q & ~value_s1;
				ACT_XMOVE, ACT_YMOVE: begin
					x_d     = x_clamp;
					y_d     = y_clamp;
					moved_d = 1'b1;
				end
				ACT_POLL: begin
					out_load = 1'b1;
					moved_d  = 1'b0;
					unique case (conn_q)
						CONN_INIT: begin
							conn_d = CONN_LIVE;
							link_d = LINK_INIT;
						end
						CONN_LIVE: link_d = LINK_LIVE;
						CONN_NONE: link_d = LINK_NONE;
						default:   link_d = LINK_OTHER;
					endcase
					unique case (phase_q) inside
						PH_NONE: if (left)  phase_d = PH_DOWN;
						PH_DOWN, PH_MOVE: phase_d = left ? PH_MOVE : PH_UP;
						PH_UP:   if (!left) phase_d = PH_NONE;
						default: ;
					endcase
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q         <= '0;
			y_q         <= '0;
			mask_q      <= 8'd0;
			conn_q      <= CONN_NONE;
			phase_q     <= PH_NONE;
			moved_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			x_q     <= x_d;
			y_q     <= y_d;
			mask_q  <= mask_d;
			conn_q  <= conn_d;
			phase_q <= phase_d;
			moved_q <= moved_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			ox_q       <= x_q;
			oy_q       <= y_q;
			ophase_q   <= phase_code(phase_d);
			orefresh_q <= moved_q;
			olink_q    <= link_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_W'({olink_q, orefresh_q, ophase_q, oy_q, ox_q});

endmodule
`default_nettype wire

@@ rtl/mct_checker.sv @@
// Port-level checks for the mouse cursor tracker, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module mct_checker
	import mct_pkg::*;
#(
	parameter int COORD_BITS = 12
) (
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 s_tvalid,
	input wire logic                 s_tready,
	input wire logic [IN_W-1:0]      s_tdata,
	input wire logic                 m_tvalid,
	input wire logic                 m_tready,
	input wire logic [((2*COORD_BITS+5+7)/8)*8-1:0] m_tdata
);

	// hold a stalled report
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("stalled output beat changed");

	// a fresh report rises only from an accepted poll beat, via the input and result registers
	a_rise_from_poll: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready && (s_tdata[2:0] == ACT_POLL), 2))
		else $error("output beat without a preceding poll");

	// input back-pressure only while a report is stuck
	a_ready_drop: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (m_tvalid && !m_tready))
		else $error("input stalled without output stall");

endmodule

bind mouse_cursor_tracker mct_checker #(.COORD_BITS(COORD_BITS)) u_mct_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
`default_nettype wire

@@ test/tb_mouse_cursor_tracker.sv @@
// Self-checking testbench for the mouse cursor tracker: directed table, then random phases.
`timescale 1ns / 1ps
`default_nettype none
module tb_mouse_cursor_tracker;
	import mct_pkg::*;

	localparam int COORD_W      = 12;
	localparam int OUT_W        = ((2*COORD_W+5+7)/8)*8;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int PHASE_ITEMS  = 85;
	localparam int DRAIN_CYCLES = 8;
	localparam int HOLD_CYCLES  = 400;
	localparam int NUM_ROWS     = 25;
	localparam int NUM_SETTINGS = 8;

	localparam logic [2:0]          ACT_SPARE   = 3'd7;
	localparam logic [IDX_BITS-1:0] REG_SPARE_A = 2'd2;
	localparam logic [IDX_BITS-1:0] REG_SPARE_B = 2'd3;

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [1:0]         phase;
		logic               refresh;
		logic [1:0]         link;
	} report_t;

	localparam report_t NO_LIT = '0;

	typedef struct {
		logic [2:0] act;
		logic [7:0] value;
		bit         has_lit;
		report_t    lit;
	} plan_row_t;

	typedef struct {
		logic [SIZE_BITS-1:0] width;
		logic [SIZE_BITS-1:0] height;
		bit                   heavy;
		bit                   drift_up;
		bit                   spare_writes;
	} screen_setting_t;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [IN_W-1:0]      s_tdata;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [OUT_W-1:0]     m_tdata;
	logic                 cfg_we;
	logic [IDX_BITS-1:0]  cfg_index;
	logic [SIZE_BITS-1:0] cfg_data;

	// shadow state of the tracker
	logic [SIZE_BITS-1:0] scr_w;
	logic [SIZE_BITS-1:0] scr_h;
	logic [COORD_W-1:0]   cur_x;
	logic [COORD_W-1:0]   cur_y;
	logic [7:0]           buttons;
	conn_t                link_state;
	logic [1:0]           cur_phase;
	logic                 moved;

	report_t poll_reports[$];
	int      errors;
	int      cycle_count;
	int      burst_left;
	bit      drift_up;
	bit      hold_off_req;

	plan_row_t directed_plan [0:NUM_ROWS-1] = '{
		'{ACT_POLL,       8'h00, 1'b1, '{12'd0,   12'd0, PCODE_NONE, 1'b0, LINK_NONE}},
		'{ACT_XMOVE,      8'h80, 1'b0, NO_LIT},
		'{ACT_POLL,       8'h00, 1'b1, '{12'd0,   12'd0, PCODE_NONE, 1'b1, LINK_NONE}},
		'{ACT_XMOVE,      8'h7F, 1'b0, NO_LIT},
		'{ACT_YMOVE,      8'hFF, 1'b0, NO_LIT},
		'{ACT_CONNECT,    8'h00, 1'b0, NO_LIT},
		'{ACT_POLL,       8'hFF, 1'b1, '{12'd127, 12'd0, PCODE_NONE, 1'b1, LINK_INIT}},
		'{ACT_POLL,       8'h00, 1'b1, '{12'd127, 12'd0, PCODE_NONE, 1'b0, LINK_LIVE}},
		'{ACT_PRESS,      8'hFF, 1'b0, NO_LIT},
		'{ACT_POLL,       8'h00, 1'b1, '{12'd127, 12'd0, PCODE_DOWN, 1'b0, LINK_LIVE}},
		'{ACT_POLL,       8'h00, 1'b1, '{12'd127, 12'd0, PCODE_MOVE, 1'b0, LINK_LIVE}},
		'{ACT_RELEASE,    8'h01, 1'b0, NO_LIT},
		'{ACT_POLL,       8'h00, 1'b1, '{12'd127, 12'd0, PCODE_UP,   1'b0, LINK_LIVE}},
		'{ACT_PRESS,      8'h01, 1'b0, NO_LIT},
		'{ACT_POLL,       8'h00, 1'b1, '{12'd127, 12'd0, PCODE_UP,   1'b0, LINK_LIVE}},
		'{ACT_RELEASE,    8'hFF, 1'b0, NO_LIT},
		'{ACT_POLL,       8'h00, 1'b1, '{12'd127, 12'd0, PCODE_NONE, 1'b0, LINK_LIVE}},
		'{ACT_POLL,       8'h00, 1'b0, NO_LIT},
		'{ACT_SPARE,      8'hAA, 1'b0, NO_LIT},
		'{ACT_YMOVE,      8'h55, 1'b0, NO_LIT},
		'{ACT_PRESS,      8'h01, 1'b0, NO_LIT},
		'{ACT_POLL,       8'h00, 1'b0, NO_LIT},
		'{ACT_DISCONNECT, 8'h5A, 1'b0, NO_LIT},
		'{ACT_POLL,       8'h00, 1'b0, NO_LIT},
		'{ACT_POLL,       8'h00, 1'b0, NO_LIT}
	};

	screen_setting_t screen_plan [0:NUM_SETTINGS-1] = '{
		'{13'd1,    13'd1,    1'b0, 1'b1, 1'b0},
		'{13'd0,    13'd0,    1'b0, 1'b1, 1'b0},
		'{13'd4096, 13'd4096, 1'b1, 1'b1, 1'b0},
		'{13'd8191, 13'd8191, 1'b1, 1'b1, 1'b0},
		'{13'd8191, 13'd0,    1'b1, 1'b0, 1'b0},
		'{13'd0,    13'd0,    1'b0, 1'b0, 1'b0},
		'{13'h0AAA, 13'h1555, 1'b1, 1'b1, 1'b1},
		'{13'd800,  13'd480,  1'b0, 1'b0, 1'b0}
	};

	mouse_cursor_tracker #(.COORD_BITS(COORD_W)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	function automatic logic [COORD_W-1:0] clamp_coord(input int pos,
			input logic [SIZE_BITS-1:0] size);
		int top;
		top = (size == '0) ? 0 : int'(size) - 1;
		if (top > (1 << COORD_W) - 1)
			top = (1 << COORD_W) - 1;
		if (pos < 0)
			pos = 0;
		if (pos > top)
			pos = top;
		return pos[COORD_W-1:0];
	endfunction

	// Apply one accepted event to the shadow state; a poll yields a report.
	task automatic track_event(input logic [2:0] act, input logic [7:0] value,
			output bit produces, output report_t rep);
		int  delta;
		bit  left;
		delta = int'($signed(value));
		produces = 1'b0;
		rep = '0;
		case (act) inside
			ACT_CONNECT: begin
				link_state = CONN_INIT;
			end
			ACT_DISCONNECT: begin
				link_state = CONN_NONE;
				buttons = '0;
			end
			ACT_PRESS: begin
				buttons = buttons | value;
			end
			ACT_RELEASE: begin
				buttons = buttons & ~value;
			end
			ACT_XMOVE, ACT_YMOVE: begin
				cur_x = clamp_coord(int'(cur_x) + ((act == ACT_XMOVE) ? delta : 0), scr_w);
				cur_y = clamp_coord(int'(cur_y) + ((act == ACT_YMOVE) ? delta : 0), scr_h);
				moved = 1'b1;
			end
			ACT_POLL: begin
				produces = 1'b1;
				case (link_state)
					CONN_INIT: begin
						link_state = CONN_LIVE;
						rep.link = LINK_INIT;
					end
					CONN_LIVE: rep.link = LINK_LIVE;
					CONN_NONE: rep.link = LINK_NONE;
					default:   rep.link = LINK_OTHER;
				endcase
				left = buttons[0];
				if (cur_phase == PCODE_NONE && left)
					cur_phase = PCODE_DOWN;
				else if ((cur_phase == PCODE_DOWN || cur_phase == PCODE_MOVE) && left)
					cur_phase = PCODE_MOVE;
				else if (cur_phase == PCODE_DOWN || cur_phase == PCODE_MOVE)
					cur_phase = PCODE_UP;
				else if (cur_phase == PCODE_UP && !left)
					cur_phase = PCODE_NONE;
				rep.x = cur_x;
				rep.y = cur_y;
				rep.phase = cur_phase;
				rep.refresh = moved;
				moved = 1'b0;
			end
			default: ;
		endcase
	endtask

	// Insert a random gap between bursts of back-to-back beats.
	task automatic pace_sender();
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				@(negedge clk);
				s_tvalid = 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
	endtask

	task automatic offer_event(input logic [2:0] act, input logic [7:0] value,
			input bit has_lit, input report_t lit);
		bit      produces;
		report_t rep;
		@(negedge clk);
		s_tvalid = 1'b1;
		s_tdata = {5'b0, value, act};
		do @(posedge clk); while (!s_tready);
		track_event(act, value, produces, rep);
		if (produces)
			poll_reports.push_back(has_lit ? lit : rep);
	endtask

	task automatic random_event(input bit heavy, output logic [2:0] act);
		int         pick;
		logic [7:0] mag;
		logic [7:0] value;
		pick = $urandom_range(0, 99);
		if (pick < (heavy ? 70 : 45)) begin
			act = $urandom_range(0, 1) ? ACT_XMOVE : ACT_YMOVE;
			if ($urandom_range(0, 39) == 0)
				drift_up = ~drift_up;
			if ($urandom_range(0, 3) != 0) begin
				mag = 8'($urandom_range(64, 127));
				value = drift_up ? mag : ~mag + 8'd1;
			end else begin
				value = 8'($urandom);
			end
		end else begin
			pick = $urandom_range(0, 99);
			if (pick < 50)
				act = ACT_POLL;
			else if (pick < 68)
				act = ACT_PRESS;
			else if (pick < 86)
				act = ACT_RELEASE;
			else if (pick < 92)
				act = ACT_CONNECT;
			else if (pick < 97)
				act = ACT_DISCONNECT;
			else
				act = ACT_SPARE;
			value = ($urandom_range(0, 2) == 0) ? 8'h01 : 8'($urandom);
		end
		pace_sender();
		offer_event(act, value, 1'b0, NO_LIT);
	endtask

	// Drop valid, wait for every report, then let the last events retire.
	task automatic settle();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (poll_reports.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [IDX_BITS-1:0] index,
			input logic [SIZE_BITS-1:0] data);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = index;
		cfg_data = data;
		@(posedge clk);
		if (index == REG_WIDTH)
			scr_w = data;
		else if (index == REG_HEIGHT)
			scr_h = data;
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		report_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (poll_reports.size() == 0) begin
				$error("report beat with none pending: %h", m_tdata);
				errors++;
			end else begin
				want = poll_reports.pop_front();
				check_field("x_position", want.x, m_tdata[11:0]);
				check_field("y_position", want.y, m_tdata[23:12]);
				check_field("cursor_phase", want.phase, m_tdata[25:24]);
				check_field("window_refresh", want.refresh, m_tdata[26]);
				check_field("link_code", want.link, m_tdata[28:27]);
			end
		end
	end

	// Receiver: stall pattern changes every so often; one long hold-off on request.
	initial begin
		int mode;
		int mode_left;
		int held;
		m_tready = 1'b0;
		mode = 0;
		mode_left = 0;
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				m_tready = 1'b0;
				for (held = 1; held < HOLD_CYCLES; held++)
					@(negedge clk);
			end else begin
				if (mode_left == 0) begin
					mode = $urandom_range(0, 3);
					mode_left = $urandom_range(16, 96);
				end
				mode_left--;
				case (mode)
					0:       m_tready = 1'b1;
					1:       m_tready = 1'($urandom_range(0, 1));
					2:       m_tready = (cycle_count % 5) >= 2;
					default: m_tready = ($urandom_range(0, 9) == 0);
				endcase
			end
		end
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		int         i;
		int         k;
		int         n;
		logic [2:0] act;
		cycle_count = 0;
		errors = 0;
		burst_left = 0;
		drift_up = 1'b1;
		hold_off_req = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		scr_w = WIDTH_RESET;
		scr_h = HEIGHT_RESET;
		cur_x = '0;
		cur_y = '0;
		buttons = '0;
		link_state = CONN_NONE;
		cur_phase = PCODE_NONE;
		moved = 1'b0;
		arst_n = 1'b0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		for (i = 0; i < NUM_ROWS; i++) begin
			pace_sender();
			offer_event(directed_plan[i].act, directed_plan[i].value,
				directed_plan[i].has_lit, directed_plan[i].lit);
		end

		for (k = 0; k < NUM_SETTINGS; k++) begin
			settle();
			write_reg(REG_WIDTH, screen_plan[k].width);
			write_reg(REG_HEIGHT, screen_plan[k].height);
			if (screen_plan[k].spare_writes) begin
				write_reg(REG_SPARE_A, 13'($urandom));
				write_reg(REG_SPARE_B, 13'h1FFF);
			end
			@(negedge clk);
			cfg_we = 1'b0;
			drift_up = screen_plan[k].drift_up;
			// starve the output while events keep coming
			if (k == 3)
				hold_off_req = 1'b1;
			n = 0;
			while (n < PHASE_ITEMS) begin
				random_event(screen_plan[k].heavy, act);
				if (act != ACT_SPARE)
					n++;
			end
		end

		settle();
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
`default_nettype wire
